### src/b32d_pkg.sv
// b32d_pkg: shared types and constants for the streaming base32 decoder
// no dependencies; used by b32d_symbol, b32d_core and base32_decoder

package b32d_pkg;

    // payload of one input transaction
    typedef struct packed {
        logic [7:0] in_char;
        logic       final_char;
    } t_in;

    // payload of one result transaction
    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       msg_done;
        logic       decode_error;
    } t_out;

    // symbol lookup result
    typedef struct packed {
        logic       valid;
        logic [4:0] value;
    } t_sym;

    localparam logic [7:0] PAD_CHAR      = 8'h3D;
    localparam logic [7:0] DIGIT_ZERO    = 8'h30;
    localparam logic [7:0] DIGIT_NINE    = 8'h39;
    localparam logic [7:0] DIGIT_TWO     = 8'h32;
    localparam logic [7:0] DIGIT_SEVEN   = 8'h37;
    localparam logic [7:0] LETTER_A      = 8'h41;
    localparam logic [7:0] LETTER_V      = 8'h56;
    localparam logic [7:0] LETTER_Z      = 8'h5A;
    localparam logic [7:0] HEX_LETTER_OFS = 8'h37;  // 'A' maps to 10
    localparam logic [7:0] STD_DIGIT_OFS  = 8'h18;  // '2' maps to 26

    localparam logic [2:0] LAST_POSITION = 3'd7;
    localparam logic [2:0] MAX_PADS      = 3'd7;

endpackage

### src/b32d_symbol.sv
// b32d_symbol: maps one character to its 5-bit symbol in the selected alphabet
// depends on b32d_pkg

module b32d_symbol (
    input  logic             i_hex,
    input  logic [7:0]       i_char,
    output b32d_pkg::t_sym   o_sym
);

    always_comb begin
        o_sym = '0;
        if (i_hex) begin
            unique case (i_char) inside
                [b32d_pkg::DIGIT_ZERO:b32d_pkg::DIGIT_NINE]: begin
                    o_sym.valid = 1'b1;
                    o_sym.value = 5'(i_char - b32d_pkg::DIGIT_ZERO);
                end
                [b32d_pkg::LETTER_A:b32d_pkg::LETTER_V]: begin
                    o_sym.valid = 1'b1;
                    o_sym.value = 5'(i_char - b32d_pkg::HEX_LETTER_OFS);
                end
                default: o_sym = '0;
            endcase
        end else begin
            unique case (i_char) inside
                [b32d_pkg::LETTER_A:b32d_pkg::LETTER_Z]: begin
                    o_sym.valid = 1'b1;
                    o_sym.value = 5'(i_char - b32d_pkg::LETTER_A);
                end
                [b32d_pkg::DIGIT_TWO:b32d_pkg::DIGIT_SEVEN]: begin
                    o_sym.valid = 1'b1;
                    o_sym.value = 5'(i_char - b32d_pkg::STD_DIGIT_OFS);
                end
                default: o_sym = '0;
            endcase
        end
    end

endmodule

### src/b32d_core.sv
// b32d_core: per-message decode state and the result of one character
// depends on b32d_pkg; instantiates b32d_symbol

module b32d_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_hex,
    input  logic            i_step,
    input  b32d_pkg::t_in   i_item,
    output b32d_pkg::t_out  o_result
);

    logic [11:0] r_acc,       n_acc;
    logic [2:0]  r_held,      n_held;
    logic [2:0]  r_group_pos, n_group_pos;
    logic [2:0]  r_data_pos,  n_data_pos;
    logic [2:0]  r_pad_cnt,   n_pad_cnt;
    logic        r_in_pad,    n_in_pad;
    logic        r_full,      n_full;
    logic        r_err,       n_err;

    b32d_pkg::t_sym sym;
    logic           is_pad;
    logic [11:0]    acc_shift;
    logic [3:0]     held_sum;
    logic [2:0]     held_left;
    logic [11:0]    keep_mask;
    logic           fin_err;

    b32d_symbol u_symbol (
        .i_hex  (i_hex),
        .i_char (i_item.in_char),
        .o_sym  (sym)
    );

    always_comb begin
        is_pad      = (i_item.in_char == b32d_pkg::PAD_CHAR);
        acc_shift   = {r_acc[6:0], sym.value};
        held_sum    = {1'b0, r_held} + 4'd5;
        held_left   = 3'(held_sum - 4'd8);
        keep_mask   = 12'((12'd1 << held_left) - 12'd1);

        n_acc       = r_acc;
        n_held      = r_held;
        n_data_pos  = r_data_pos;
        n_pad_cnt   = r_pad_cnt;
        n_in_pad    = r_in_pad;
        n_err       = r_err;
        o_result    = '0;

        if (is_pad) begin
            if (r_pad_cnt == b32d_pkg::MAX_PADS) begin
                n_err = 1'b1;
            end else begin
                n_pad_cnt = r_pad_cnt + 3'd1;
            end
            n_in_pad = 1'b1;
        end else if (!sym.valid || r_in_pad) begin
            n_err = 1'b1;
        end else begin
            n_data_pos = r_data_pos + 3'd1;
            if (held_sum >= 4'd8) begin
                // a byte is complete: take the top eight pending bits
                o_result.out_byte   = 8'(acc_shift >> held_left);
                o_result.byte_valid = 1'b1;
                n_held              = held_left;
                n_acc               = acc_shift & keep_mask;
            end else begin
                n_held = held_sum[2:0];
                n_acc  = acc_shift;
            end
        end

        n_full      = r_full | (r_group_pos == b32d_pkg::LAST_POSITION);
        n_group_pos = r_group_pos + 3'd1;

        // end-of-message checks
        fin_err = n_err;
        if (is_pad) begin
            if (n_group_pos != 3'd0 || !n_full) fin_err = 1'b1;
        end else if (n_in_pad) begin
            fin_err = 1'b1;
        end
        if (n_data_pos == 3'd1 || n_data_pos == 3'd3 || n_data_pos == 3'd6) begin
            fin_err = 1'b1;
        end

        if (i_item.final_char) begin
            o_result.msg_done     = 1'b1;
            o_result.decode_error = fin_err;
            n_acc       = '0;
            n_held      = '0;
            n_group_pos = '0;
            n_data_pos  = '0;
            n_pad_cnt   = '0;
            n_in_pad    = 1'b0;
            n_full      = 1'b0;
            n_err       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_held      <= '0;
            r_group_pos <= '0;
            r_data_pos  <= '0;
            r_pad_cnt   <= '0;
            r_in_pad    <= 1'b0;
            r_full      <= 1'b0;
            r_err       <= 1'b0;
        end else if (i_step) begin
            r_acc       <= n_acc;
            r_held      <= n_held;
            r_group_pos <= n_group_pos;
            r_data_pos  <= n_data_pos;
            r_pad_cnt   <= n_pad_cnt;
            r_in_pad    <= n_in_pad;
            r_full      <= n_full;
            r_err       <= n_err;
        end
    end

endmodule

### src/base32_decoder.sv
// base32_decoder: top level of the streaming base32 decoder
// depends on b32d_pkg; instantiates b32d_core
//
// usage
//   input channel: one character per transaction (i_in_valid / o_in_stall),
//   with final_char set on the last character of a message
//   output channel: exactly one result per character (o_out_valid /
//   i_out_stall); byte_valid marks a decoded byte, msg_done marks the
//   result of the final character and carries decode_error
//   on decode_error the bytes already delivered for that message are bad
//   hex_alphabet register: i_cfg_wr_en / i_cfg_wr_data, 0 = A-Z,2-7,
//   1 = 0-9,A-V; write it only while the decoder is idle
// timing
//   a character sits one cycle in the input register, is decoded by the
//   alphabet lookup and shift logic, and lands in the output register:
//   two cycles from acceptance to result, one character per cycle sustained,
//   set by the single-cycle update of the accumulator state
// reset and stall
//   synchronous active-low reset empties both registers, clears message
//   state and selects the standard alphabet
//   a stalled output holds its result; the input register still takes one
//   more character, then o_in_stall rises until the output drains

module base32_decoder (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  b32d_pkg::t_in   i_in,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output b32d_pkg::t_out  o_out
);

    logic            r_hex;
    logic            r_in_valid;
    b32d_pkg::t_in   r_in;
    logic            r_out_valid;
    b32d_pkg::t_out  r_out;

    b32d_pkg::t_out  result;
    logic            out_free;
    logic            step;
    logic            in_take;

    // output register can take a new result when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    // decode the held character when its result has somewhere to go
    assign step       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    b32d_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_hex    (r_hex),
        .i_step   (step),
        .i_item   (r_in),
        .o_result (result)
    );

    // alphabet select register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hex <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_hex <= i_cfg_wr_data;
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_in;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= step;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

### test/base32_decoder_checker.sv
// base32_decoder_checker: watches both channels of the base32 decoder, predicts each result
// and compares it field by field with what the block delivers
// depends on b32d_pkg; instantiated beside the block by tb_base32_decoder

module base32_decoder_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic            i_cfg_wr_data,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  b32d_pkg::t_in   i_in,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  b32d_pkg::t_out  i_out,
    output int              o_errors,
    output int              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int PRINT_LIMIT = 100;

    // decoder state as seen by the prediction
    logic        hex_sel;
    logic [11:0] acc_bits;
    logic [3:0]  acc_count;
    logic [2:0]  char_pos;
    logic [2:0]  data_pos;
    logic [2:0]  pad_cnt;
    logic        padding;
    logic        group_done;
    logic        msg_err;

    b32d_pkg::t_out expected_results[$];
    int             result_index = 0;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic report_mismatch(input string what);
        if (o_errors < PRINT_LIMIT) begin
            $display("ERROR: result %0d at %0t: %s", result_index, $realtime, what);
        end
        o_errors++;
    endtask

    task automatic clear_message();
        acc_bits   = '0;
        acc_count  = '0;
        char_pos   = '0;
        data_pos   = '0;
        pad_cnt    = '0;
        padding    = 1'b0;
        group_done = 1'b0;
        msg_err    = 1'b0;
    endtask

    function automatic b32d_pkg::t_sym lookup_symbol(input logic [7:0] c, input logic hex);
        b32d_pkg::t_sym s;
        logic [7:0]     ofs;
        s   = '0;
        ofs = '0;
        if (hex) begin
            if (c >= b32d_pkg::DIGIT_ZERO && c <= b32d_pkg::DIGIT_NINE) begin
                ofs = c - b32d_pkg::DIGIT_ZERO;
                s.valid = 1'b1;
            end else if (c >= b32d_pkg::LETTER_A && c <= b32d_pkg::LETTER_V) begin
                ofs = c - b32d_pkg::LETTER_A + 8'd10;
                s.valid = 1'b1;
            end
        end else begin
            if (c >= b32d_pkg::LETTER_A && c <= b32d_pkg::LETTER_Z) begin
                ofs = c - b32d_pkg::LETTER_A;
                s.valid = 1'b1;
            end else if (c >= b32d_pkg::DIGIT_TWO && c <= b32d_pkg::DIGIT_SEVEN) begin
                ofs = c - b32d_pkg::DIGIT_TWO + 8'd26;
                s.valid = 1'b1;
            end
        end
        s.value = ofs[4:0];
        return s;
    endfunction

    task automatic predict_char(input b32d_pkg::t_in c, output b32d_pkg::t_out r);
        b32d_pkg::t_sym s;
        logic           is_pad;
        int unsigned    held;
        logic [11:0]    shifted;
        r      = '0;
        is_pad = (c.in_char == b32d_pkg::PAD_CHAR);
        if (is_pad) begin
            if (pad_cnt == b32d_pkg::MAX_PADS) msg_err = 1'b1;
            else pad_cnt = pad_cnt + 3'd1;
            padding = 1'b1;
        end else begin
            s = lookup_symbol(c.in_char, hex_sel);
            if (!s.valid || padding) begin
                msg_err = 1'b1;
            end else begin
                acc_bits = {acc_bits[6:0], s.value};
                held     = acc_count + 5;
                if (held >= 8) begin
                    held         = held - 8;
                    shifted      = acc_bits >> held;
                    r.out_byte   = shifted[7:0];
                    r.byte_valid = 1'b1;
                    acc_bits     = acc_bits & ((12'd1 << held) - 12'd1);
                end
                acc_count = held[3:0];
                data_pos  = data_pos + 3'd1;
            end
        end
        if (char_pos == b32d_pkg::LAST_POSITION) group_done = 1'b1;
        char_pos = char_pos + 3'd1;

        if (c.final_char) begin
            r.msg_done     = 1'b1;
            r.decode_error = msg_err;
            if (is_pad) begin
                if (char_pos != 3'd0 || !group_done) r.decode_error = 1'b1;
            end else if (padding) begin
                r.decode_error = 1'b1;
            end
            // leftover symbol counts that cannot end a byte sequence
            case (data_pos)
                3'd1, 3'd3, 3'd6: r.decode_error = 1'b1;
                default: ;
            endcase
            clear_message();
        end
    endtask

    always @(posedge i_clk) begin
        b32d_pkg::t_out want;
        b32d_pkg::t_out got;
        if (!i_rst_n) begin
            hex_sel = 1'b0;
            clear_message();
            expected_results.delete();
        end else begin
            if (i_cfg_wr_en) hex_sel = i_cfg_wr_data;

            if (i_out_valid && !i_out_stall) begin
                got = i_out;
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with nothing expected: %p", got));
                end else begin
                    want = expected_results.pop_front();
                    if (got.out_byte !== want.out_byte)
                        report_mismatch($sformatf("out_byte expected %h got %h",
                                                  want.out_byte, got.out_byte));
                    if (got.byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid expected %b got %b",
                                                  want.byte_valid, got.byte_valid));
                    if (got.msg_done !== want.msg_done)
                        report_mismatch($sformatf("msg_done expected %b got %b",
                                                  want.msg_done, got.msg_done));
                    if (got.decode_error !== want.decode_error)
                        report_mismatch($sformatf("decode_error expected %b got %b",
                                                  want.decode_error, got.decode_error));
                end
                result_index++;
            end

            if (i_in_valid && !i_in_stall) begin
                predict_char(i_in, want);
                expected_results.push_back(want);
            end
        end
        o_pending = expected_results.size();
    end

endmodule

### test/tb_base32_decoder.sv
// tb_base32_decoder: stimulus and verdict for the streaming base32 decoder
// depends on b32d_pkg, base32_decoder and base32_decoder_checker

module tb_base32_decoder;

    timeunit 1ns;
    timeprecision 1ps;

    // cycles without any transaction before the run is declared hung
    localparam int IDLE_LIMIT   = 2000;
    localparam int SEGMENT_SIZE = 300;
    localparam int DRAIN_CYCLES = 4;

    // ways a well-formed message gets broken
    localparam int MUT_RANDOM_BYTE = 0;
    localparam int MUT_PAD_INSIDE  = 1;
    localparam int MUT_EXTRA_PAD   = 2;
    localparam int MUT_DROP_CHAR   = 3;
    localparam int MUT_LOWERCASE   = 4;

    logic           clk         = 1'b0;
    logic           rst_n       = 1'b0;
    logic           cfg_wr_en   = 1'b0;
    logic           cfg_wr_data = 1'b0;
    logic           in_valid    = 1'b0;
    logic           in_stall;
    b32d_pkg::t_in  in_item     = '0;
    logic           out_valid;
    logic           out_stall   = 1'b0;
    b32d_pkg::t_out out_result;

    int mismatches;
    int outstanding;

    // idle rates in percent, changed per phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int chars_sent     = 0;
    int idle_cycles    = 0;

    always #1 clk = ~clk;

    base32_decoder i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_in         (in_item),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_out        (out_result)
    );

    base32_decoder_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in         (in_item),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out        (out_result),
        .o_errors     (mismatches),
        .o_pending    (outstanding)
    );

    // receiver back-pressure, redrawn every falling edge
    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < recv_stall_pct);
    end

    // watchdog: any accepted transaction on either side restarts the count
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // one character transaction; returns at the rising edge that accepted it,
    // valid stays up so back-to-back characters need no gap
    task automatic send_char(input logic [7:0] ch, input logic last);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid           = 1'b1;
        in_item.in_char    = ch;
        in_item.final_char = last;
        do @(posedge clk); while (in_stall);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) send_char(s[i], i == s.len() - 1);
    endtask

    // drain the decoder completely, then write the alphabet select
    task automatic load_alphabet(input logic hex);
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = hex;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [7:0] alphabet_char(input logic hex, input logic [4:0] sym);
        if (hex) begin
            return (sym < 10) ? b32d_pkg::DIGIT_ZERO + sym : b32d_pkg::LETTER_A + sym - 8'd10;
        end
        return (sym < 26) ? b32d_pkg::LETTER_A + sym : b32d_pkg::DIGIT_TWO + sym - 8'd26;
    endfunction

    // one random message: mostly well-formed, some broken, some pure noise
    task automatic send_message(input logic hex);
        logic [7:0] msg[$];
        int         kind;
        int         groups;
        int         tail;
        int         k;
        kind = $urandom_range(99);
        if (kind < 85) begin
            // legal data counts in the final group are 0, 2, 4, 5 and 7
            groups = $urandom_range(2);
            case ($urandom_range(4))
                0: tail = 0;
                1: tail = 2;
                2: tail = 4;
                3: tail = 5;
                default: tail = 7;
            endcase
            if (groups == 0 && tail == 0) tail = 2;
            repeat (groups * 8 + tail) begin
                msg.push_back(alphabet_char(hex, 5'($urandom_range(31))));
            end
            if (tail != 0 && $urandom_range(1)) begin
                repeat (8 - tail) msg.push_back(b32d_pkg::PAD_CHAR);
            end

            if (kind >= 60) begin
                k = $urandom_range(msg.size() - 1);
                case ($urandom_range(MUT_LOWERCASE))
                    MUT_RANDOM_BYTE: msg[k] = 8'($urandom_range(255));
                    MUT_PAD_INSIDE:  msg[k] = b32d_pkg::PAD_CHAR;
                    MUT_EXTRA_PAD:   msg.push_back(b32d_pkg::PAD_CHAR);
                    MUT_DROP_CHAR:   if (msg.size() > 1) msg.delete(k);
                    default:         msg[k] = msg[k] | 8'h20;
                endcase
            end
        end else begin
            // noise covers every code point, pad included
            repeat ($urandom_range(12, 1)) msg.push_back(8'($urandom_range(255)));
        end
        foreach (msg[i]) send_char(msg[i], i == msg.size() - 1);
    endtask

    initial begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed, standard alphabet
        load_alphabet(1'b0);
        send_text("77777777");          // highest symbol everywhere, five 0xff bytes
        send_text("A");                 // single data char leaves an unusable count
        send_text("a");                 // lowercase is outside the alphabet
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b1);
        send_text("=");                 // lone pad, message too short

        // directed, hex alphabet
        load_alphabet(1'b1);
        send_text("V=0");               // data after a pad, pad not at the end
        send_text("========");          // eighth pad overflows the pad count

        // random phases: receiver-heavy stalls, sender-heavy idling, then full rate
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 15;
                    recv_stall_pct = 67;
                end
                1: begin
                    send_idle_pct  = 67;
                    recv_stall_pct = 15;
                end
                default: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int alph = 0; alph < 2; alph++) begin
                load_alphabet(alph[0]);
                chars_sent = 0;
                while (chars_sent < SEGMENT_SIZE) send_message(alph[0]);
            end
        end

        // let every expected result come back, then a little slack
        @(negedge clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
